>>> hdl/controller_sample_conditioner_core_assert.svh
// ----------------------------------------------------------------------------
// Controller sample conditioner assertion macros
// Concurrent assertion wrappers shared by the conditioner RTL. They expand to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CONTROLLER_SAMPLE_CONDITIONER_CORE_ASSERT_SVH
`define CONTROLLER_SAMPLE_CONDITIONER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define CSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csc assertion failed");

// Next-cycle implication, disabled during reset.
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csc assertion failed");

`else

`define CSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/csc_pkg.sv
// ----------------------------------------------------------------------------
// Controller sample conditioner package
// Item types, codes, arithmetic widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package csc_pkg;

    // Default number of controller channels.
    localparam int NUM_CHANNELS_DEF = 4;

    // Input action codes.
    localparam logic ACTION_SAMPLE  = 1'b0;
    localparam logic ACTION_NO_CTRL = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_CTRL = 1'b1;

    // Device kind codes.
    localparam logic DEVICE_CORE = 1'b0;
    localparam logic DEVICE_EXT  = 1'b1;

    // Resting acceleration on the y axis is -1.0 g in Q3.12.
    localparam logic signed [15:0] ACC_REST_Y = -16'sd4096;

    // Saturation limits of the result fields.
    localparam logic [15:0] MAG_MAX   = 16'hFFFF;
    localparam logic [16:0] SPEED_MAX = 17'h1FFFF;

    // Square root unit: an 18-bit root of a 36-bit radicand, two bits a cycle.
    localparam int ROOT_W              = 18;
    localparam int RAD_W               = 2 * ROOT_W;
    localparam int REM_W               = ROOT_W + 2;
    localparam int SQRT_BITS_PER_CYCLE = 2;
    localparam int SQRT_ITERS          = ROOT_W / SQRT_BITS_PER_CYCLE;
    localparam int SQRT_CNT_W          = $clog2(SQRT_ITERS + 1);

    // Width of one absolute axis difference and of its square.
    localparam int DIFF_W = 17;
    localparam int SQ_W   = 2 * DIFF_W;

    typedef struct packed {
        logic              action;
        logic [1:0]        channel;
        logic [31:0]       held_buttons;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic              nunchuk_attached;
        logic signed [15:0] ext_acc_x;
        logic signed [15:0] ext_acc_y;
        logic signed [15:0] ext_acc_z;
    } t_in_item;

    typedef struct packed {
        logic        entry_count;
        logic        status_code;
        logic [31:0] buttons_held;
        logic [31:0] buttons_pressed;
        logic [31:0] buttons_released;
        logic [15:0] acc_magnitude;
        logic [16:0] acc_speed;
        logic        device_kind;
        logic [15:0] ext_magnitude;
        logic [16:0] ext_speed;
    } t_out_item;

    // One 3-axis acceleration vector.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec3;

    // Which of the four lengths the datapath is working on.
    typedef enum logic [1:0] {
        VEC_REM_MAG = 2'd0,
        VEC_REM_SPD = 2'd1,
        VEC_EXT_MAG = 2'd2,
        VEC_EXT_SPD = 2'd3
    } t_vec_sel;

    typedef struct packed {
        logic     load_in;
        logic     square;
        logic     start_root;
        logic     store_root;
        logic     commit;
        t_vec_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic no_ctrl;
        logic has_ext;
        logic root_done;
    } t_dp_status;

endpackage

>>> hdl/csc_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Restoring digit-by-digit root, two result bits per cycle, floor result.
// ----------------------------------------------------------------------------
module csc_sqrt
    import csc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [SQRT_CNT_W-1:0] r_count;
    logic                  r_busy;
    logic                  r_done;

    // Two dependent root steps per cycle.
    always_comb begin : sqrt_step
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  trial;
        rad   = r_rad;
        rem   = r_rem;
        root  = r_root;
        trial = '0;
        for (int k = 0; k < SQRT_BITS_PER_CYCLE; k++) begin
            rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
            rad   = {rad[RAD_W-3:0], 2'b00};
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[ROOT_W-2:0], 1'b1};
            end else begin
                root = {root[ROOT_W-2:0], 1'b0};
            end
        end
        n_rad  = rad;
        n_rem  = rem;
        n_root = root;
    end

    // Control of the iteration count and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= SQRT_CNT_W'(SQRT_ITERS);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == SQRT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers of the root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> hdl/csc_datapath.sv
// ----------------------------------------------------------------------------
// Conditioner datapath
// Item register, per-channel state, squarers, shared square root and the
// result register.
// ----------------------------------------------------------------------------
module csc_datapath
    import csc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_in_item          r_in;
    logic [31:0]       r_last_btn [NUM_CHANNELS];
    t_vec3             r_last_rem [NUM_CHANNELS];
    t_vec3             r_last_ext [NUM_CHANNELS];
    logic [SQ_W-1:0]   r_sq [3];
    logic [15:0]       r_acc_mag;
    logic [16:0]       r_acc_spd;
    logic [15:0]       r_ext_mag;
    logic [16:0]       r_ext_spd;
    t_out_item         r_out, n_out;

    logic [CH_W+1:0]   chan_wide;
    logic [CH_W-1:0]   idx;
    logic              in_range;
    logic              no_ctrl;
    logic              has_ext;
    t_vec3             cur_rem;
    t_vec3             cur_ext;
    t_vec3             vec_cur;
    t_vec3             vec_prev;
    logic [DIFF_W-1:0] ad_x, ad_y, ad_z;
    logic [RAD_W-1:0]  radicand;
    logic              root_done;
    logic [ROOT_W-1:0] root;
    logic [15:0]       root_mag;
    logic [16:0]       root_spd;

    // Absolute difference of two signed axis values.
    function automatic logic [DIFF_W-1:0] abs_diff(logic signed [15:0] a,
                                                   logic signed [15:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    // Item register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    // Channel decode.
    assign chan_wide = {{CH_W{1'b0}}, r_in.channel};
    assign idx       = chan_wide[CH_W-1:0];
    assign in_range  = (chan_wide < (CH_W + 2)'(NUM_CHANNELS));
    assign no_ctrl   = (r_in.action == ACTION_NO_CTRL);
    assign has_ext   = r_in.nunchuk_attached;

    assign cur_rem = '{x: r_in.acc_x, y: r_in.acc_y, z: r_in.acc_z};
    assign cur_ext = '{x: r_in.ext_acc_x, y: r_in.ext_acc_y, z: r_in.ext_acc_z};

    // Operand selection for the vector being measured.
    always_comb begin
        unique case (i_cmd.sel)
            VEC_REM_MAG: begin
                vec_cur  = cur_rem;
                vec_prev = '0;
            end
            VEC_REM_SPD: begin
                vec_cur  = cur_rem;
                vec_prev = r_last_rem[idx];
            end
            VEC_EXT_MAG: begin
                vec_cur  = cur_ext;
                vec_prev = '0;
            end
            VEC_EXT_SPD: begin
                vec_cur  = cur_ext;
                vec_prev = r_last_ext[idx];
            end
            default: begin
                vec_cur  = cur_rem;
                vec_prev = '0;
            end
        endcase
    end

    assign ad_x = abs_diff(vec_cur.x, vec_prev.x);
    assign ad_y = abs_diff(vec_cur.y, vec_prev.y);
    assign ad_z = abs_diff(vec_cur.z, vec_prev.z);

    // Squares of the three axis differences, one multiplier per axis.
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq[0] <= ad_x * ad_x;
            r_sq[1] <= ad_y * ad_y;
            r_sq[2] <= ad_z * ad_z;
        end
    end

    assign radicand = RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);

    csc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_root),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root)
    );

    // Saturated views of the root.
    assign root_mag = (root > ROOT_W'(MAG_MAX))   ? MAG_MAX   : root[15:0];
    assign root_spd = (root > ROOT_W'(SPEED_MAX)) ? SPEED_MAX : root[16:0];

    // Keep each finished length.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_root) begin
            unique case (i_cmd.sel)
                VEC_REM_MAG: r_acc_mag <= root_mag;
                VEC_REM_SPD: r_acc_spd <= root_spd;
                VEC_EXT_MAG: r_ext_mag <= root_mag;
                VEC_EXT_SPD: r_ext_spd <= root_spd;
                default:     r_acc_mag <= root_mag;
            endcase
        end
    end

    // Result assembly.
    always_comb begin
        n_out = '0;
        if (in_range && !no_ctrl) begin
            n_out.entry_count      = 1'b1;
            n_out.status_code      = STATUS_OK;
            n_out.buttons_held     = r_in.held_buttons;
            n_out.buttons_pressed  = r_in.held_buttons & ~r_last_btn[idx];
            n_out.buttons_released = r_last_btn[idx] & ~r_in.held_buttons;
            n_out.acc_magnitude    = r_acc_mag;
            n_out.acc_speed        = r_acc_spd;
            n_out.device_kind      = has_ext ? DEVICE_EXT : DEVICE_CORE;
            n_out.ext_magnitude    = has_ext ? r_ext_mag : '0;
            n_out.ext_speed        = has_ext ? r_ext_spd : '0;
        end else if (in_range) begin
            n_out.status_code = STATUS_NO_CTRL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // Per-channel history, updated when the result is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_last_btn[c] <= '0;
                r_last_rem[c] <= '{x: 16'sd0, y: ACC_REST_Y, z: 16'sd0};
                r_last_ext[c] <= '{x: 16'sd0, y: ACC_REST_Y, z: 16'sd0};
            end
        end else if (i_cmd.commit && in_range) begin
            if (no_ctrl) begin
                r_last_btn[idx] <= '0;
                r_last_rem[idx] <= '{x: 16'sd0, y: ACC_REST_Y, z: 16'sd0};
                r_last_ext[idx] <= '{x: 16'sd0, y: ACC_REST_Y, z: 16'sd0};
            end else begin
                r_last_btn[idx] <= r_in.held_buttons;
                r_last_rem[idx] <= cur_rem;
                if (has_ext) begin
                    r_last_ext[idx] <= cur_ext;
                end
            end
        end
    end

    assign o_status.in_range  = in_range;
    assign o_status.no_ctrl   = no_ctrl;
    assign o_status.has_ext   = has_ext;
    assign o_status.root_done = root_done;
    assign o_out_data         = r_out;

endmodule

>>> hdl/csc_ctrl.sv
// ----------------------------------------------------------------------------
// Conditioner controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "controller_sample_conditioner_core_assert.svh"

module csc_ctrl
    import csc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SQUARE,
        S_ROOT_START,
        S_ROOT_WAIT,
        S_FINISH
    } t_state;

    t_state   r_state;
    t_vec_sel r_sel;
    logic     r_out_valid;
    logic     out_free;
    logic     ext_square;

    // The result register can take a new value when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // State, vector select and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= VEC_REM_MAG;
            r_out_valid <= 1'b0;
        end else begin
            // A commit refills the result register; otherwise a drain empties it.
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (!i_status.in_range || i_status.no_ctrl) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_sel   <= VEC_REM_MAG;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_state <= S_ROOT_START;
                end
                S_ROOT_START: begin
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (i_status.root_done) begin
                        unique case (r_sel)
                            VEC_REM_MAG: begin
                                r_sel   <= VEC_REM_SPD;
                                r_state <= S_SQUARE;
                            end
                            VEC_REM_SPD: begin
                                if (i_status.has_ext) begin
                                    r_sel   <= VEC_EXT_MAG;
                                    r_state <= S_SQUARE;
                                end else begin
                                    r_state <= S_FINISH;
                                end
                            end
                            VEC_EXT_MAG: begin
                                r_sel   <= VEC_EXT_SPD;
                                r_state <= S_SQUARE;
                            end
                            VEC_EXT_SPD: begin
                                r_state <= S_FINISH;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb begin
        o_cmd            = '0;
        o_cmd.sel        = r_sel;
        o_cmd.load_in    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.square     = (r_state == S_SQUARE);
        o_cmd.start_root = (r_state == S_ROOT_START);
        o_cmd.store_root = (r_state == S_ROOT_WAIT) && i_status.root_done;
        o_cmd.commit     = (r_state == S_FINISH) && out_free;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Squaring cycle of one of the extension vectors.
    assign ext_square = (r_state == S_SQUARE) &&
                        ((r_sel == VEC_EXT_MAG) || (r_sel == VEC_EXT_SPD));

    // A committed result is offered in the next cycle.
    `CSC_ASSERT_NEXT(a_commit_offers, i_clk, i_rst_n, o_cmd.commit, o_out_valid)
    // An accepted transfer always starts decoding.
    `CSC_ASSERT_NEXT(a_load_decodes, i_clk, i_rst_n, o_cmd.load_in, r_state == S_DECODE)
    // The root unit finishes only while the controller waits for it.
    `CSC_ASSERT_IMPL(a_root_in_wait, i_clk, i_rst_n, i_status.root_done, r_state == S_ROOT_WAIT)
    // Extension lengths are computed only when an extension is attached.
    `CSC_ASSERT_IMPL(a_ext_only, i_clk, i_rst_n, ext_square, i_status.has_ext)

endmodule

>>> hdl/controller_sample_conditioner_core.sv
// ----------------------------------------------------------------------------
// Controller sample conditioner
// Per-channel button edge detection and acceleration length/speed for
// controller samples.
// ----------------------------------------------------------------------------
// Each accepted transfer takes one sample or no-controller notice and yields
// exactly one result transfer. A no-controller or out-of-range item goes
// from decode straight to the result. A sample uses the single shared
// square-root unit, which produces two root bits per cycle, once for each
// of its vector lengths (two without an extension, four with one), each
// preceded by a squaring step and a root load step. A new item is accepted
// as soon as the previous one is in the output register, even if that
// result is still stalled.
module controller_sample_conditioner_core
    import csc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer.
    csc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and channel state.
    csc_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

endmodule
